[hdl/ppm_pkg.sv]
// shared types and constants for the pendulum period meter
package ppm_pkg;

   // command codes
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_ARM    = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ARMED = 2'd1;
   localparam logic [1:0] PH_RUN   = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OSC       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF   = 3'd4;

   // 4*pi^2 scaled by 1e6, and the 1e6 / 1e9 scale factors
   localparam logic [25:0] FOUR_PI_SQ_E6 = 26'd39478418;
   localparam logic [19:0] SCALE_E6      = 20'd1000000;
   localparam logic [63:0] SCALE_E9      = 64'd1000000000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] accel_y;
      logic [31:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic        peak_event;
      logic        done_event;
      logic [8:0]  crossings;
      logic [31:0] period_us;
      logic [31:0] freq_mhz;
      logic [23:0] gravity_mm_s2;
   } rsp_type;

endpackage

[hdl/pendulum_period_meter_top.sv]
// pendulum period meter: phase tracking, ema, peak and crossing detection, result math
// a word that does not finish a run gives its result in the cycle after acceptance
// a finishing word runs three 64-step divisions (only the period division when the period is
// zero) on one shared restoring divider plus the MUL1 and MUL2 states; one word in flight
// reset (synchronous, active high) returns phase to idle, clears the measurement state and
// results (not the divider datapath), and loads the register defaults 0, 819, 10, 500, 250
module pendulum_period_meter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ppm_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ppm_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                     csr_data
);

   localparam logic [39:0] FOUR_PI_SQ_E6_EXT = 40'(ppm_pkg::FOUR_PI_SQ_E6);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_P,
      ST_MUL1,
      ST_MUL2,
      ST_DIV_F,
      ST_DIV_G
   } st_type;

   st_type             st_ff, st_in;

   // configuration registers
   logic signed [15:0] base_ff;
   logic [14:0]        thr_ff;
   logic [7:0]         osc_ff;
   logic [13:0]        len_ff;
   logic [15:0]        hold_ff;

   // measurement state
   logic [1:0]         phase_ff, phase_in;
   logic signed [15:0] smooth_ff, smooth_in;
   logic               rising_ff, rising_in;
   logic [31:0]        lastpk_ff, lastpk_in;
   logic               swpos_ff, swpos_in;
   logic [8:0]         cross_ff, cross_in;
   logic [31:0]        start_ff, start_in;
   logic [31:0]        period_ff, period_in;
   logic [31:0]        freq_ff, freq_in;
   logic [23:0]        grav_ff, grav_in;
   logic               peak_ff, peak_in;
   logic               done_ff, done_in;
   logic               rspv_ff, rspv_in;

   // shared divider and product registers
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        dq_ff, dq_in;
   logic [63:0]        dvs_ff, dvs_in;
   logic [63:0]        pp_ff, pp_in;
   logic [39:0]        numa_ff, numa_in;

   // sample path
   logic signed [16:0] x_val;
   logic [16:0]        mag;
   logic signed [27:0] ema_sum;
   logic signed [17:0] ema_sh;
   logic signed [15:0] ema_sat;
   logic signed [17:0] thr_s;
   logic               rise_now;
   logic [31:0]        since_pk;
   logic [7:0]         n_eff;
   logic [8:0]         cross_lim;
   logic [8:0]         cross_inc;
   logic [31:0]        run_ms;
   logic [41:0]        run_us;

   // divider step
   logic [64:0]        r_sh;
   logic [64:0]        r_diff;
   logic               r_ge;
   logic [63:0]        rem_step;
   logic [63:0]        q_step;

   assign req_ready = (st_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign csr_ready = 1'b1;

   assign rsp_data.phase         = phase_ff;
   assign rsp_data.peak_event    = peak_ff;
   assign rsp_data.done_event    = done_ff;
   assign rsp_data.crossings     = cross_ff;
   assign rsp_data.period_us     = period_ff;
   assign rsp_data.freq_mhz      = freq_ff;
   assign rsp_data.gravity_mm_s2 = grav_ff;

   // baseline removal, magnitude and ema (floor of the >>10 is an arithmetic shift)
   assign x_val   = 17'(req_data.accel_y) - 17'(base_ff);
   assign mag     = x_val[16] ? 17'(-x_val) : 17'(x_val);
   assign ema_sum = 28'(x_val) * 28'sd410 + 28'(smooth_ff) * 28'sd614;
   assign ema_sh  = 18'(ema_sum >>> 10);
   assign ema_sat = (ema_sh > 18'sd32767)  ? 16'sh7fff :
                    (ema_sh < -18'sd32768) ? 16'sh8000 : 16'(ema_sh);
   assign thr_s    = 18'($signed({3'b000, thr_ff}));
   assign rise_now = ema_sat > smooth_ff;
   assign since_pk = req_data.time_ms - lastpk_ff;

   // zero target counts as one oscillation; run ends at 2n+1 crossings
   assign n_eff     = (osc_ff == 8'd0) ? 8'd1 : osc_ff;
   assign cross_lim = {n_eff, 1'b1};
   assign cross_inc = (cross_ff == 9'd511) ? cross_ff : cross_ff + 9'd1;
   assign run_ms    = req_data.time_ms - start_ff;
   assign run_us    = 42'(run_ms) * 42'd1000;

   // one restoring step: shift in a dividend bit, subtract if it fits
   assign r_sh     = {rem_ff, dq_ff[63]};
   assign r_diff   = r_sh - {1'b0, dvs_ff};
   assign r_ge     = !r_diff[64];
   assign rem_step = r_ge ? r_diff[63:0] : r_sh[63:0];
   assign q_step   = {dq_ff[62:0], r_ge};

   always_comb begin
      st_in     = st_ff;
      phase_in  = phase_ff;
      smooth_in = smooth_ff;
      rising_in = rising_ff;
      lastpk_in = lastpk_ff;
      swpos_in  = swpos_ff;
      cross_in  = cross_ff;
      start_in  = start_ff;
      period_in = period_ff;
      freq_in   = freq_ff;
      grav_in   = grav_ff;
      peak_in   = peak_ff;
      done_in   = done_ff;
      rspv_in   = rspv_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      dvs_in    = dvs_ff;
      pp_in     = pp_ff;
      numa_in   = numa_ff;

      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end

      case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               peak_in = 1'b0;
               done_in = 1'b0;
               rspv_in = 1'b1;
               case (req_data.command)
                  ppm_pkg::CMD_ARM: begin
                     if (phase_ff == ppm_pkg::PH_IDLE) begin
                        phase_in = ppm_pkg::PH_ARMED;
                     end
                  end
                  ppm_pkg::CMD_CLEAR: begin
                     period_in = '0;
                     freq_in   = '0;
                     grav_in   = '0;
                     cross_in  = '0;
                     swpos_in  = 1'b0;
                     phase_in  = ppm_pkg::PH_IDLE;
                  end
                  ppm_pkg::CMD_SAMPLE: begin
                     if (phase_ff == ppm_pkg::PH_ARMED) begin
                        if (mag > 17'(thr_ff)) begin
                           phase_in  = ppm_pkg::PH_RUN;
                           smooth_in = '0;
                           rising_in = 1'b0;
                           lastpk_in = '0;
                        end
                     end else if (phase_ff == ppm_pkg::PH_RUN) begin
                        if (since_pk > 32'(hold_ff)) begin
                           if ((rising_ff && !rise_now && 18'(ema_sat) > thr_s) ||
                               (!rising_ff && rise_now && 18'(ema_sat) < -thr_s)) begin
                              peak_in   = 1'b1;
                              lastpk_in = req_data.time_ms;
                           end
                        end
                        rising_in = rise_now;
                        smooth_in = ema_sat;
                        if ((x_val > 17'sd0) != swpos_ff) begin
                           swpos_in = (x_val > 17'sd0);
                           if (cross_ff == 9'd0) begin
                              start_in = req_data.time_ms;
                           end
                           cross_in = cross_inc;
                           if (cross_inc >= cross_lim) begin
                              // run complete: start period division, hold the result back
                              done_in  = 1'b1;
                              phase_in = ppm_pkg::PH_DONE;
                              rspv_in  = 1'b0;
                              rem_in   = '0;
                              dq_in    = 64'(run_us);
                              dvs_in   = 64'(n_eff);
                              cnt_in   = 6'd63;
                              st_in    = ST_DIV_P;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_P: begin
            rem_in = rem_step;
            dq_in  = q_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               period_in = (q_step[63:32] != 32'd0) ? 32'hffff_ffff : q_step[31:0];
               if (period_in == 32'd0) begin
                  freq_in = '0;
                  grav_in = '0;
                  rspv_in = 1'b1;
                  st_in   = ST_IDLE;
               end else begin
                  st_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            pp_in   = 64'(period_ff) * 64'(period_ff);
            numa_in = 40'(len_ff) * 40'(FOUR_PI_SQ_E6_EXT);
            st_in   = ST_MUL2;
         end
         ST_MUL2: begin
            // frequency first; gravity numerator parked in numa, period squared in pp
            numa_in = numa_ff;
            rem_in  = '0;
            dq_in   = ppm_pkg::SCALE_E9;
            dvs_in  = 64'(period_ff);
            cnt_in  = 6'd63;
            st_in   = ST_DIV_F;
         end
         ST_DIV_F: begin
            rem_in = rem_step;
            dq_in  = q_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               freq_in = q_step[31:0];
               rem_in  = '0;
               dq_in   = 64'(numa_ff) * 64'(ppm_pkg::SCALE_E6);
               dvs_in  = pp_ff;
               st_in   = ST_DIV_G;
            end
         end
         ST_DIV_G: begin
            rem_in = rem_step;
            dq_in  = q_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               grav_in = (q_step[63:24] != 40'd0) ? 24'hff_ffff : q_step[23:0];
               rspv_in = 1'b1;
               st_in   = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         base_ff   <= '0;
         thr_ff    <= 15'd819;
         osc_ff    <= 8'd10;
         len_ff    <= 14'd500;
         hold_ff   <= 16'd250;
         phase_ff  <= ppm_pkg::PH_IDLE;
         smooth_ff <= '0;
         rising_ff <= 1'b0;
         lastpk_ff <= '0;
         swpos_ff  <= 1'b0;
         cross_ff  <= '0;
         start_ff  <= '0;
         period_ff <= '0;
         freq_ff   <= '0;
         grav_ff   <= '0;
         peak_ff   <= 1'b0;
         done_ff   <= 1'b0;
         rspv_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         phase_ff  <= phase_in;
         smooth_ff <= smooth_in;
         rising_ff <= rising_in;
         lastpk_ff <= lastpk_in;
         swpos_ff  <= swpos_in;
         cross_ff  <= cross_in;
         start_ff  <= start_in;
         period_ff <= period_in;
         freq_ff   <= freq_in;
         grav_ff   <= grav_in;
         peak_ff   <= peak_in;
         done_ff   <= done_in;
         rspv_ff   <= rspv_in;
         cnt_ff    <= cnt_in;
         // register writes, indexes past the list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ppm_pkg::REG_BASELINE:  base_ff <= csr_data;
               ppm_pkg::REG_THRESHOLD: thr_ff  <= csr_data[14:0];
               ppm_pkg::REG_OSC:       osc_ff  <= csr_data[7:0];
               ppm_pkg::REG_LENGTH:    len_ff  <= csr_data[13:0];
               ppm_pkg::REG_HOLDOFF:   hold_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // divider and product datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      dvs_ff  <= dvs_in;
      pp_ff   <= pp_in;
      numa_ff <= numa_in;
   end

   // a finished run is always reported in the done phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && done_ff |-> phase_ff == ppm_pkg::PH_DONE)
      else $error("done word outside done phase");

   // no result shown while the divider is busy
   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !rspv_ff)
      else $error("result valid during result math");

   // a zero period never carries frequency or gravity
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && period_ff == 32'd0 |-> freq_ff == 32'd0 && grav_ff == 24'd0)
      else $error("nonzero result with zero period");

   // leaving the last division always presents a result
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DIV_G && cnt_ff == 6'd0 |=> rspv_ff && st_ff == ST_IDLE)
      else $error("gravity division did not complete");

endmodule

[tb/sv/pendulum_period_meter_top_tb.sv]
// self-checking testbench for the pendulum period meter
module pendulum_period_meter_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // expected-result tracker with its own copy of the meter state
   class period_scoreboard;
      int          baseline;
      int          threshold;
      int unsigned osc_target;
      int unsigned length_mm;
      int unsigned holdoff;

      logic [1:0]  phase;
      int          smooth;
      bit          was_rising;
      logic [31:0] last_peak;
      bit          swing_pos;
      int unsigned crossings;
      logic [31:0] start_ms;
      logic [31:0] period;
      logic [31:0] freq;
      logic [23:0] gravity;

      ppm_pkg::rsp_type pending_rsp[$];
      int          errors;

      function void reset_state();
         baseline = 0;
         threshold = 819;
         osc_target = 10;
         length_mm = 500;
         holdoff = 250;
         phase = ppm_pkg::PH_IDLE;
         smooth = 0;
         was_rising = 0;
         last_peak = '0;
         start_ms = '0;
         clear_results();
      endfunction

      function void clear_results();
         period = '0;
         freq = '0;
         gravity = '0;
         crossings = 0;
         swing_pos = 0;
      endfunction

      function void set_reg(logic [ppm_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
         case (idx)
            ppm_pkg::REG_BASELINE:  baseline = int'($signed(value));
            ppm_pkg::REG_THRESHOLD: threshold = int'(value[14:0]);
            ppm_pkg::REG_OSC:       osc_target = 32'(value[7:0]);
            ppm_pkg::REG_LENGTH:    length_mm = 32'(value[13:0]);
            ppm_pkg::REG_HOLDOFF:   holdoff = 32'(value);
            default: ;
         endcase
      endfunction

      // period, frequency and gravity at the end of a run
      function void compute_results(logic [31:0] now, int unsigned n);
         longint unsigned total, p, g;
         logic [31:0] elapsed;
         elapsed = now - start_ms;
         total = 64'(elapsed);
         p = total * 1000 / n;
         if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
         period = p[31:0];
         if (p == 0) begin
            freq = '0;
            gravity = '0;
         end else begin
            freq = 32'(64'd1000000000 / p);
            g = (64'd39478418 * length_mm * 64'd1000000) / (p * p);
            if (g > 64'hFF_FFFF) g = 64'hFF_FFFF;
            gravity = g[23:0];
         end
         phase = ppm_pkg::PH_DONE;
      endfunction

      // accepted input word: work out the one result it causes
      function void note(ppm_pkg::req_type r);
         int          x, mag;
         longint      s;
         bit          rising, pos;
         bit          peak, done;
         int unsigned n;
         logic [31:0] now, since_peak;
         ppm_pkg::rsp_type e;
         x = int'(r.accel_y) - baseline;
         now = r.time_ms;
         peak = 0;
         done = 0;
         if (r.command == ppm_pkg::CMD_ARM) begin
            if (phase == ppm_pkg::PH_IDLE) phase = ppm_pkg::PH_ARMED;
         end else if (r.command == ppm_pkg::CMD_CLEAR) begin
            clear_results();
            phase = ppm_pkg::PH_IDLE;
         end else if (r.command == ppm_pkg::CMD_SAMPLE) begin
            if (phase == ppm_pkg::PH_ARMED) begin
               mag = x < 0 ? -x : x;
               if (mag > threshold) begin
                  phase = ppm_pkg::PH_RUN;
                  smooth = 0;
                  was_rising = 0;
                  last_peak = '0;
               end
            end else if (phase == ppm_pkg::PH_RUN) begin
               // arithmetic shift gives the floor of the division by 1024
               s = (410 * longint'(x) + 614 * longint'(smooth)) >>> 10;
               if (s > 32767) s = 32767;
               if (s < -32768) s = -32768;
               n = osc_target != 0 ? osc_target : 1;
               rising = s > smooth;
               since_peak = now - last_peak;
               if (since_peak > holdoff) begin
                  if ((was_rising && !rising && s > threshold) ||
                      (!was_rising && rising && s < -threshold)) begin
                     peak = 1;
                     last_peak = now;
                  end
               end
               was_rising = rising;
               smooth = int'(s);
               pos = x > 0;
               if (pos != swing_pos) begin
                  swing_pos = pos;
                  if (crossings == 0) start_ms = now;
                  if (crossings < 511) crossings++;
                  if (crossings >= 2 * n + 1) begin
                     compute_results(now, n);
                     done = 1;
                  end
               end
            end
         end
         e.phase = phase;
         e.peak_event = peak;
         e.done_event = done;
         e.crossings = crossings[8:0];
         e.period_us = period;
         e.freq_mhz = freq;
         e.gravity_mm_s2 = gravity;
         pending_rsp.push_back(e);
      endfunction

      function void check(ppm_pkg::rsp_type a);
         ppm_pkg::rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (a.phase !== e.phase) begin
            $error("phase: expected %0d, got %0d", e.phase, a.phase);
            errors++;
         end
         if (a.peak_event !== e.peak_event) begin
            $error("peak_event: expected %0d, got %0d", e.peak_event, a.peak_event);
            errors++;
         end
         if (a.done_event !== e.done_event) begin
            $error("done_event: expected %0d, got %0d", e.done_event, a.done_event);
            errors++;
         end
         if (a.crossings !== e.crossings) begin
            $error("crossings: expected %0d, got %0d", e.crossings, a.crossings);
            errors++;
         end
         if (a.period_us !== e.period_us) begin
            $error("period_us: expected %0d, got %0d", e.period_us, a.period_us);
            errors++;
         end
         if (a.freq_mhz !== e.freq_mhz) begin
            $error("freq_mhz: expected %0d, got %0d", e.freq_mhz, a.freq_mhz);
            errors++;
         end
         if (a.gravity_mm_s2 !== e.gravity_mm_s2) begin
            $error("gravity_mm_s2: expected %0d, got %0d", e.gravity_mm_s2,
                   a.gravity_mm_s2);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   ppm_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   ppm_pkg::rsp_type              rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [ppm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                   csr_data;

   period_scoreboard sb;
   int   words_sent;
   bit   quiet;          // no idling on either side near the end
   bit   long_hold;      // asks the receiver for one long stall
   int   cycle_count = 0;
   logic [31:0] clock_ms;  // running timestamp for well-formed swings

   pendulum_period_meter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // watchdog: stops a hung simulation and reports errors
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
   end

   // receiver: random stall bursts, one long hold on request, none when quiet
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one word and hold it until accepted
   task automatic send_word(logic [1:0] cmd, logic [15:0] accel, logic [31:0] tms);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= '{command: cmd, accel_y: accel, time_ms: tms};
      do @(posedge clock); while (!req_ready);
      sb.note(req_data);
      words_sent++;
      // sender gap, a random burst of idle cycles
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
   endtask

   // wait until every expected word has come back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_reg(logic [ppm_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_regs(logic [15:0] base, logic [15:0] thr, logic [15:0] osc,
                            logic [15:0] len, logic [15:0] hold);
      write_reg(ppm_pkg::REG_BASELINE, base);
      write_reg(ppm_pkg::REG_THRESHOLD, thr);
      write_reg(ppm_pkg::REG_OSC, osc);
      write_reg(ppm_pkg::REG_LENGTH, len);
      write_reg(ppm_pkg::REG_HOLDOFF, hold);
   endtask

   // sometimes clear, then arm, then a triangle swing around the baseline
   task automatic swing_run(int samples);
      int amp, half, k, pos, v, acc, dt;
      amp = int'($urandom_range(200, 12000));
      half = int'($urandom_range(2, 12));
      dt = int'($urandom_range(1, 60));
      if ($urandom_range(0, 3) == 0)
         send_word(ppm_pkg::CMD_CLEAR, 16'($urandom), $urandom);
      send_word(ppm_pkg::CMD_ARM, 16'($urandom), clock_ms);
      for (k = 0; k < samples; k++) begin
         pos = k % (2 * half);
         if (pos < half) v = amp - 2 * amp * pos / half;
         else v = -amp + 2 * amp * (pos - half) / half;
         v += int'($urandom_range(0, 200)) - 100;
         acc = sb.baseline + v;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         clock_ms += 32'(dt);
         send_word(ppm_pkg::CMD_SAMPLE, acc[15:0], clock_ms);
      end
   endtask

   // a stretch of random swings mixed with noise words
   task automatic random_phase(int words);
      int stop_at;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0)
            send_word(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
         else
            swing_run(int'($urandom_range(8, 60)));
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      words_sent = 0;
      quiet = 0;
      long_hold = 0;
      clock_ms = $urandom;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: status before arming, ignored codes, field extremes
      send_word(ppm_pkg::CMD_SAMPLE, 16'h7FFF, 32'h0);
      send_word(ppm_pkg::CMD_UNUSED, 16'h8000, 32'hFFFF_FFFF);
      send_word(ppm_pkg::CMD_ARM, 16'h0, 32'h0);
      send_word(ppm_pkg::CMD_ARM, 16'h0, 32'h0);                // arm while armed
      send_word(ppm_pkg::CMD_SAMPLE, 16'd100, 32'd10);         // below threshold
      send_word(ppm_pkg::CMD_SAMPLE, 16'h7FFF, 32'hFFFF_FFF0); // starts the run
      send_word(ppm_pkg::CMD_ARM, 16'h0, 32'hFFFF_FFF8);       // arm while running
      send_word(ppm_pkg::CMD_SAMPLE, 16'h8000, 32'hFFFF_FFFC);
      send_word(ppm_pkg::CMD_SAMPLE, 16'h7FFF, 32'd4);         // timestamp wraps
      send_word(ppm_pkg::CMD_SAMPLE, 16'h8000, 32'd300);
      send_word(ppm_pkg::CMD_UNUSED, 16'h1234, 32'd310);
      send_word(ppm_pkg::CMD_CLEAR, 16'h0, 32'd320);
      send_word(ppm_pkg::CMD_SAMPLE, 16'h7FFF, 32'd330);       // sample while idle
      drain();

      // one oscillation, zero holdoff: zero period when timestamps stand still
      load_regs(16'h0, 16'd0, 16'd0, 16'd1, 16'd0);
      send_word(ppm_pkg::CMD_ARM, 16'h0, 32'd0);
      send_word(ppm_pkg::CMD_SAMPLE, 16'd500, 32'd7);
      send_word(ppm_pkg::CMD_SAMPLE, -16'sd500, 32'd7);
      send_word(ppm_pkg::CMD_SAMPLE, 16'd500, 32'd7);
      send_word(ppm_pkg::CMD_SAMPLE, -16'sd500, 32'd7);
      send_word(ppm_pkg::CMD_SAMPLE, 16'd500, 32'd7);          // done, zero period
      send_word(ppm_pkg::CMD_SAMPLE, 16'd500, 32'd9);          // sample while done
      drain();

      // short runs finish often
      load_regs(16'h0, 16'd400, 16'd1, 16'd10000, 16'd0);
      random_phase(250);
      drain();

      // receiver holds off long while the sender keeps offering
      long_hold = 1;
      random_phase(80);
      drain();

      // extreme registers: large baseline, top threshold, long holdoff
      load_regs(16'h8000, 16'h7FFF, 16'd255, 16'd1, 16'hFFFF);
      random_phase(100);
      drain();
      load_regs(16'h7FFF, 16'd0, 16'd3, 16'h3FFF, 16'd250);
      random_phase(100);
      drain();

      // moderate settings for the bulk of the run
      load_regs(16'hFF00, 16'd819, 16'd2, 16'd500, 16'd20);
      random_phase(350);
      drain();

      // last part with no idling
      load_regs(16'h0, 16'd1000, 16'd1, 16'd750, 16'd5);
      quiet = 1;
      random_phase(150);
      drain();

      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (sb.pending_rsp.size() != 0) $error("expected words left over");
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
